/* hdl/bsoc_pkg.sv */
// Shared constants, curve tables and pipeline control type for the state-of-charge block.
`default_nettype none
package bsoc_pkg;

   localparam int CURVE_POINTS = 11;
   localparam int STAGES       = 6;

   localparam int V_W     = 16;
   localparam int I_W     = 16;
   localparam int SOC_W   = 7;
   localparam int CELLS_W = 5;
   localparam int IR_W    = 10;
   localparam int CSR_W   = 10;
   localparam int CSR_IDX_W = 1;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_IN_PACK = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERNAL_RES  = 1'd1;

   localparam logic [CELLS_W-1:0] CELLS_RESET = 5'd1;
   localparam logic [IR_W-1:0]    IR_RESET    = 10'd100;

   localparam logic [I_W-1:0] HEAVY_LOAD_MA     = 16'd1200;
   localparam logic [I_W-1:0] COMP_THRESHOLD_MA = 16'd100;

   // Cell count division: q = (pack * CELL_RECIP[c]) >> RECIP_SHIFT, exact for 16-bit packs.
   localparam int RECIP_W     = 22;
   localparam int RECIP_SHIFT = 21;
   localparam logic [RECIP_W-1:0] CELL_RECIP [32] = '{
      22'd2097152, 22'd2097152, 22'd1048576, 22'd699051,
      22'd524288,  22'd419431,  22'd349526,  22'd299594,
      22'd262144,  22'd233017,  22'd209716,  22'd190651,
      22'd174763,  22'd161320,  22'd149797,  22'd139811,
      22'd131072,  22'd123362,  22'd116509,  22'd110377,
      22'd104858,  22'd99865,   22'd95326,   22'd91181,
      22'd87382,   22'd83887,   22'd80660,   22'd77673,
      22'd74899,   22'd72316,   22'd69906,   22'd67651
   };

   // Division by 1000 is a shift by three and a reciprocal multiply for 125.
   localparam int IRP_W    = I_W + IR_W;
   localparam int M125_W   = 24;
   localparam int M125_SHIFT = 30;
   localparam logic [M125_W-1:0] M125 = 24'd8589935;
   localparam int COMP_W   = 17;

   localparam logic [V_W-1:0] CURVE_LIGHT [CURVE_POINTS] = '{
      16'd2600, 16'd3000, 16'd3150, 16'd3300, 16'd3450, 16'd3600,
      16'd3750, 16'd3850, 16'd3940, 16'd4040, 16'd4150
   };
   localparam logic [V_W-1:0] CURVE_HEAVY [CURVE_POINTS] = '{
      16'd2600, 16'd2900, 16'd3070, 16'd3220, 16'd3370, 16'd3520,
      16'd3670, 16'd3780, 16'd3900, 16'd3980, 16'd4100
   };
   localparam logic [SOC_W-1:0] SOC_POINTS [CURVE_POINTS] = '{
      7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
   };

   function automatic int max_span();
      int m;
      m = 0;
      for (int i = 0; i + 1 < CURVE_POINTS; i++) begin
         if (SOC_POINTS[i+1] > SOC_POINTS[i] && int'(SOC_POINTS[i+1] - SOC_POINTS[i]) > m) begin
            m = int'(SOC_POINTS[i+1] - SOC_POINTS[i]);
         end
      end
      return m;
   endfunction

   // The interpolation quotient never exceeds the widest rise in the percent table.
   localparam int QUOT_BITS = $clog2(max_span() + 1);
   localparam int NUM_W     = V_W + SOC_W;
   localparam int DIV_W     = NUM_W + 1;

   typedef struct packed {
      logic [STAGES-1:0] adv;
   } pipe_ctl_type;

endpackage
`default_nettype wire

/* hdl/bsoc_comp.sv */
// Pipeline stages one to three: per-cell voltage and resistive sag compensation.
`default_nettype none
module bsoc_comp (
   input  wire logic                            clock,
   input  wire bsoc_pkg::pipe_ctl_type          ctl,
   input  wire logic [bsoc_pkg::V_W-1:0]        pack_voltage_mv,
   input  wire logic [bsoc_pkg::I_W-1:0]        discharge_current_ma,
   input  wire logic [bsoc_pkg::CELLS_W-1:0]    cells,
   input  wire logic [bsoc_pkg::IR_W-1:0]       resistance,
   output logic      [bsoc_pkg::V_W-1:0]        volt,
   output logic                                 heavy
);

   logic [bsoc_pkg::V_W-1:0]     pack_ff;
   logic [bsoc_pkg::RECIP_W-1:0] recip_ff;
   logic [bsoc_pkg::IRP_W-1:0]   irp_ff, irp_in;
   logic                         comp_en1_ff, heavy1_ff;

   logic [bsoc_pkg::V_W+bsoc_pkg::RECIP_W-1:0] qprod;
   logic [bsoc_pkg::IRP_W-3+bsoc_pkg::M125_W-1:0] cprod;
   logic [bsoc_pkg::V_W-1:0]     cellv_ff;
   logic [bsoc_pkg::COMP_W-1:0]  comp_ff;
   logic                         comp_en2_ff, heavy2_ff;

   logic [bsoc_pkg::V_W+1:0]     sum;
   logic [bsoc_pkg::V_W-1:0]     volt_ff, volt_in;
   logic                         heavy3_ff;

   assign irp_in = bsoc_pkg::IRP_W'(discharge_current_ma) * bsoc_pkg::IRP_W'(resistance);

   always_ff @(posedge clock) begin
      if (ctl.adv[0]) begin
         pack_ff     <= pack_voltage_mv;
         recip_ff    <= bsoc_pkg::CELL_RECIP[cells];
         irp_ff      <= irp_in;
         comp_en1_ff <= discharge_current_ma > bsoc_pkg::COMP_THRESHOLD_MA;
         heavy1_ff   <= discharge_current_ma > bsoc_pkg::HEAVY_LOAD_MA;
      end
   end

   // Both reciprocal multiplies run side by side.
   assign qprod = (bsoc_pkg::V_W+bsoc_pkg::RECIP_W)'(pack_ff) *
                  (bsoc_pkg::V_W+bsoc_pkg::RECIP_W)'(recip_ff);
   assign cprod = (bsoc_pkg::IRP_W-3+bsoc_pkg::M125_W)'(irp_ff[bsoc_pkg::IRP_W-1:3]) *
                  (bsoc_pkg::IRP_W-3+bsoc_pkg::M125_W)'(bsoc_pkg::M125);

   always_ff @(posedge clock) begin
      if (ctl.adv[1]) begin
         cellv_ff    <= qprod[bsoc_pkg::RECIP_SHIFT +: bsoc_pkg::V_W];
         comp_ff     <= cprod[bsoc_pkg::M125_SHIFT +: bsoc_pkg::COMP_W];
         comp_en2_ff <= comp_en1_ff;
         heavy2_ff   <= heavy1_ff;
      end
   end

   always_comb begin
      sum = (bsoc_pkg::V_W+2)'(cellv_ff) +
            (comp_en2_ff ? (bsoc_pkg::V_W+2)'(comp_ff) : '0);
      if (sum[bsoc_pkg::V_W+1:bsoc_pkg::V_W] != 2'b00) begin
         volt_in = '1;
      end else begin
         volt_in = sum[bsoc_pkg::V_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[2]) begin
         volt_ff   <= volt_in;
         heavy3_ff <= heavy2_ff;
      end
   end

   assign volt  = volt_ff;
   assign heavy = heavy3_ff;

endmodule
`default_nettype wire

/* hdl/bsoc_interp.sv */
// Pipeline stages four to six: segment search, scaling and interpolation quotient.
`default_nettype none
module bsoc_interp (
   input  wire logic                          clock,
   input  wire bsoc_pkg::pipe_ctl_type        ctl,
   input  wire logic [bsoc_pkg::V_W-1:0]      volt,
   input  wire logic                          heavy,
   output logic      [bsoc_pkg::SOC_W-1:0]    soc
);

   logic [bsoc_pkg::V_W-1:0]   pt [bsoc_pkg::CURVE_POINTS];
   logic                       lo, hi, found;
   logic [bsoc_pkg::V_W-1:0]   diff_in, den_in;
   logic [bsoc_pkg::SOC_W-1:0] s0_in, span_in;

   logic                       done4_ff;
   logic [bsoc_pkg::SOC_W-1:0] dval4_ff, s04_ff, span_ff;
   logic [bsoc_pkg::V_W-1:0]   diff_ff, den4_ff;

   logic                       done5_ff;
   logic [bsoc_pkg::SOC_W-1:0] dval5_ff, s05_ff;
   logic [bsoc_pkg::V_W-1:0]   den5_ff;
   logic [bsoc_pkg::NUM_W-1:0] num_ff;

   logic [bsoc_pkg::DIV_W-1:0]     rem, dsh;
   logic [bsoc_pkg::QUOT_BITS-1:0] quot;
   logic [bsoc_pkg::SOC_W-1:0]     soc_ff, soc_in;

   // The lowest segment that holds the voltage wins, hence the descending overwrite.
   always_comb begin
      for (int i = 0; i < bsoc_pkg::CURVE_POINTS; i++) begin
         pt[i] = heavy ? bsoc_pkg::CURVE_HEAVY[i] : bsoc_pkg::CURVE_LIGHT[i];
      end
      lo      = volt <= pt[0];
      hi      = volt >= pt[bsoc_pkg::CURVE_POINTS-1];
      found   = 1'b0;
      diff_in = '0;
      den_in  = '0;
      s0_in   = '0;
      span_in = '0;
      for (int i = bsoc_pkg::CURVE_POINTS - 2; i >= 0; i--) begin
         if (pt[i+1] > pt[i] && volt >= pt[i] && volt <= pt[i+1]) begin
            found   = 1'b1;
            diff_in = volt - pt[i];
            den_in  = pt[i+1] - pt[i];
            s0_in   = bsoc_pkg::SOC_POINTS[i];
            span_in = (bsoc_pkg::SOC_POINTS[i+1] >= bsoc_pkg::SOC_POINTS[i]) ?
                      bsoc_pkg::SOC_POINTS[i+1] - bsoc_pkg::SOC_POINTS[i] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[3]) begin
         done4_ff <= lo || hi || !found;
         dval4_ff <= lo ? bsoc_pkg::SOC_POINTS[0] :
                          bsoc_pkg::SOC_POINTS[bsoc_pkg::CURVE_POINTS-1];
         diff_ff  <= diff_in;
         den4_ff  <= den_in;
         s04_ff   <= s0_in;
         span_ff  <= span_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[4]) begin
         num_ff   <= bsoc_pkg::NUM_W'(diff_ff) * bsoc_pkg::NUM_W'(span_ff);
         den5_ff  <= den4_ff;
         s05_ff   <= s04_ff;
         done5_ff <= done4_ff;
         dval5_ff <= dval4_ff;
      end
   end

   // Restoring division; the quotient is bounded by the segment's percent rise.
   always_comb begin
      rem  = bsoc_pkg::DIV_W'(num_ff);
      quot = '0;
      dsh  = '0;
      for (int b = bsoc_pkg::QUOT_BITS - 1; b >= 0; b--) begin
         dsh = bsoc_pkg::DIV_W'(den5_ff) << b;
         if (rem >= dsh) begin
            rem     = rem - dsh;
            quot[b] = 1'b1;
         end
      end
      soc_in = done5_ff ? dval5_ff : s05_ff + bsoc_pkg::SOC_W'(quot);
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[5]) begin
         soc_ff <= soc_in;
      end
   end

   assign soc = soc_ff;

endmodule
`default_nettype wire

/* hdl/battery_soc_from_voltage.sv */
// Six register stages; a result is held in the output register, the last of them.
// Throughput: one item per cycle while the output is not stalled; the longest stages
// are the reciprocal multiplies of stage two and the segment compare of stage four.
// Bubbles close up under a stalled output, so input is taken while a result waits.
// Reset clears all valid bits and loads cell count 1 and 100 milliohm; no clearing pass.
`default_nettype none
module battery_soc_from_voltage (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [bsoc_pkg::V_W-1:0]          req_pack_voltage_mv,
   input  wire logic [bsoc_pkg::I_W-1:0]          req_discharge_current_ma,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [bsoc_pkg::SOC_W-1:0]        rsp_soc_percent,
   input  wire logic                              csr_write_en,
   input  wire logic [bsoc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bsoc_pkg::CSR_W-1:0]        csr_wdata
);

   logic [bsoc_pkg::CELLS_W-1:0] cells_ff;
   logic [bsoc_pkg::IR_W-1:0]    ir_ff;
   logic [bsoc_pkg::STAGES-1:0]  valid_ff, valid_in, ready;
   bsoc_pkg::pipe_ctl_type       ctl;
   logic [bsoc_pkg::V_W-1:0]     volt;
   logic                         heavy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff <= bsoc_pkg::CELLS_RESET;
         ir_ff    <= bsoc_pkg::IR_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            bsoc_pkg::CSR_CELLS_IN_PACK: cells_ff <= csr_wdata[bsoc_pkg::CELLS_W-1:0];
            bsoc_pkg::CSR_INTERNAL_RES:  ir_ff    <= csr_wdata[bsoc_pkg::IR_W-1:0];
            default: ;
         endcase
      end
   end

   // A stage takes new data when it is empty or its successor moves on.
   always_comb begin
      ready[bsoc_pkg::STAGES-1] = !valid_ff[bsoc_pkg::STAGES-1] || !rsp_stall;
      for (int k = bsoc_pkg::STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < bsoc_pkg::STAGES; k++) begin
         if (ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
      ctl.adv = ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   bsoc_comp u_comp (
      .clock                (clock),
      .ctl                  (ctl),
      .pack_voltage_mv      (req_pack_voltage_mv),
      .discharge_current_ma (req_discharge_current_ma),
      .cells                (cells_ff),
      .resistance           (ir_ff),
      .volt                 (volt),
      .heavy                (heavy)
   );

   bsoc_interp u_interp (
      .clock (clock),
      .ctl   (ctl),
      .volt  (volt),
      .heavy (heavy),
      .soc   (rsp_soc_percent)
   );

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[bsoc_pkg::STAGES-1];

endmodule
`default_nettype wire

/* verif/battery_soc_checker.sv */
// Checker that predicts the state of charge for every accepted item and compares each result.
`timescale 1ns / 1ps
module battery_soc_checker (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   input  logic                                      req_stall,
   input  logic [bsoc_pkg::V_W-1:0]                  req_pack_voltage_mv,
   input  logic [bsoc_pkg::I_W-1:0]                  req_discharge_current_ma,
   input  logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   input  logic [bsoc_pkg::SOC_W-1:0]                rsp_soc_percent,
   input  logic                                      csr_write_en,
   input  logic [bsoc_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [bsoc_pkg::CSR_W-1:0]                csr_wdata,
   output int                                        mismatches,
   output int                                        outstanding,
   output int                                        checked
);

   localparam int KNOTS = 11;
   localparam int unsigned SAG_THRESHOLD_MA = 100;
   localparam int unsigned HEAVY_CURVE_MA   = 1200;
   localparam int unsigned MV_SATURATE      = 65535;

   localparam int unsigned OCV_LIGHT [KNOTS] = '{
      2600, 3000, 3150, 3300, 3450, 3600, 3750, 3850, 3940, 4040, 4150
   };
   localparam int unsigned OCV_HEAVY [KNOTS] = '{
      2600, 2900, 3070, 3220, 3370, 3520, 3670, 3780, 3900, 3980, 4100
   };
   localparam int unsigned SOC_KNOTS [KNOTS] = '{
      0, 10, 20, 30, 40, 50, 60, 70, 80, 90, 100
   };

   logic [bsoc_pkg::CELLS_W-1:0] cells_cfg;
   logic [bsoc_pkg::IR_W-1:0]    ir_cfg;
   logic [bsoc_pkg::SOC_W-1:0]   soc_due [$];

   function automatic logic [bsoc_pkg::SOC_W-1:0] soc_estimate(
         input logic [bsoc_pkg::V_W-1:0] pack,
         input logic [bsoc_pkg::I_W-1:0] cur,
         input logic [bsoc_pkg::CELLS_W-1:0] cells,
         input logic [bsoc_pkg::IR_W-1:0] ir_mohm);
      int unsigned n_cells;
      int unsigned v;
      int unsigned rise;
      int unsigned knot [KNOTS];
      n_cells = (cells == 0) ? 1 : int'(cells);
      v = int'(pack) / n_cells;
      // Resistive sag is added back only above the compensation threshold.
      if (int'(cur) > SAG_THRESHOLD_MA) begin
         v = v + (int'(cur) * int'(ir_mohm)) / 1000;
         if (v > MV_SATURATE) v = MV_SATURATE;
      end
      for (int i = 0; i < KNOTS; i++) begin
         knot[i] = (int'(cur) > HEAVY_CURVE_MA) ? OCV_HEAVY[i] : OCV_LIGHT[i];
      end
      if (v <= knot[0]) return bsoc_pkg::SOC_W'(SOC_KNOTS[0]);
      if (v >= knot[KNOTS-1]) return bsoc_pkg::SOC_W'(SOC_KNOTS[KNOTS-1]);
      // On a shared knot the lower segment wins, as the search runs upwards.
      for (int i = 0; i + 1 < KNOTS; i++) begin
         if (knot[i+1] > knot[i] && v >= knot[i] && v <= knot[i+1]) begin
            rise = (SOC_KNOTS[i+1] >= SOC_KNOTS[i]) ? SOC_KNOTS[i+1] - SOC_KNOTS[i] : 0;
            return bsoc_pkg::SOC_W'(SOC_KNOTS[i] +
                                    ((v - knot[i]) * rise) / (knot[i+1] - knot[i]));
         end
      end
      return bsoc_pkg::SOC_W'(SOC_KNOTS[KNOTS-1]);
   endfunction

   always @(posedge clock) begin : watch
      logic [bsoc_pkg::SOC_W-1:0] want;
      if (reset) begin
         soc_due.delete();
         cells_cfg = bsoc_pkg::CELLS_RESET;
         ir_cfg = bsoc_pkg::IR_RESET;
         mismatches = 0;
         checked = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (soc_due.size() == 0) begin
               mismatches++;
               $error("soc_percent: no item outstanding, actual %0d", rsp_soc_percent);
            end else begin
               want = soc_due.pop_front();
               checked++;
               if (rsp_soc_percent !== want) begin
                  mismatches++;
                  $error("soc_percent: expected %0d, actual %0d", want, rsp_soc_percent);
               end
            end
         end
         if (req_valid && !req_stall) begin
            soc_due.push_back(soc_estimate(req_pack_voltage_mv, req_discharge_current_ma,
                                           cells_cfg, ir_cfg));
         end
         if (csr_write_en) begin
            if (csr_index == bsoc_pkg::CSR_CELLS_IN_PACK) begin
               cells_cfg = csr_wdata[bsoc_pkg::CELLS_W-1:0];
            end else if (csr_index == bsoc_pkg::CSR_INTERNAL_RES) begin
               ir_cfg = csr_wdata[bsoc_pkg::IR_W-1:0];
            end
         end
      end
      outstanding = soc_due.size();
   end

endmodule

/* verif/tb_battery_soc_from_voltage.sv */
// Testbench top: clock, reset, sample and register stimulus, output stalls and the verdict.
`timescale 1ns / 1ps
module tb_battery_soc_from_voltage;

   localparam int CYCLE_LIMIT      = 300000;
   localparam int PHASES           = 9;
   localparam int ITEMS_PER_PHASE  = 136;
   localparam int LONG_HOLD_AT     = 360;
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int DRAIN_CYCLES     = 12;
   localparam int EDGE_ITEMS       = 24;

   // Corner samples: curve ends and knots, both load thresholds, saturation and bit patterns.
   localparam logic [bsoc_pkg::V_W-1:0] EDGE_PACK [EDGE_ITEMS] = '{
      16'd0,    16'd65535, 16'd65535, 16'd0,    16'd2600, 16'd2599, 16'd4150, 16'd4149,
      16'd3000, 16'd3001,  16'd3075,  16'd3000, 16'd3000, 16'd3500, 16'd3500, 16'd3900,
      16'd4100, 16'd2900,  16'd4000,  16'd2700, 16'hAAAA, 16'h5555, 16'd3850, 16'd3940
   };
   localparam logic [bsoc_pkg::I_W-1:0] EDGE_CUR [EDGE_ITEMS] = '{
      16'd0,    16'd0,     16'd65535, 16'd65535, 16'd0,   16'd0,    16'd0,    16'd0,
      16'd0,    16'd0,     16'd50,    16'd100,   16'd101, 16'd1200, 16'd1201, 16'd1201,
      16'd1500, 16'd1300,  16'd0,     16'd99,    16'h5555, 16'hAAAA, 16'd0,   16'd400
   };

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [bsoc_pkg::V_W-1:0]       req_pack_voltage_mv;
   logic [bsoc_pkg::I_W-1:0]       req_discharge_current_ma;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [bsoc_pkg::SOC_W-1:0]     rsp_soc_percent;
   logic                           csr_write_en;
   logic [bsoc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [bsoc_pkg::CSR_W-1:0]     csr_wdata;

   int mismatches;
   int outstanding;
   int checked;
   int cycle_count = 0;
   int offered = 0;
   logic [bsoc_pkg::CELLS_W-1:0] cells_now = bsoc_pkg::CELLS_RESET;
   logic [bsoc_pkg::IR_W-1:0]    ir_now = bsoc_pkg::IR_RESET;

   battery_soc_from_voltage u_dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_pack_voltage_mv      (req_pack_voltage_mv),
      .req_discharge_current_ma (req_discharge_current_ma),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_soc_percent          (rsp_soc_percent),
      .csr_write_en             (csr_write_en),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata)
   );

   battery_soc_checker u_checker (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_pack_voltage_mv      (req_pack_voltage_mv),
      .req_discharge_current_ma (req_discharge_current_ma),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_soc_percent          (rsp_soc_percent),
      .csr_write_en             (csr_write_en),
      .csr_index                (csr_index),
      .csr_wdata                (csr_wdata),
      .mismatches               (mismatches),
      .outstanding              (outstanding),
      .checked                  (checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL battery_soc_from_voltage");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic offer_sample(input logic [bsoc_pkg::V_W-1:0] pack,
                               input logic [bsoc_pkg::I_W-1:0] cur);
      int unsigned gap;
      gap = (offered % 64 < 16) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_pack_voltage_mv <= bsoc_pkg::V_W'($urandom);
         req_discharge_current_ma <= bsoc_pkg::I_W'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pack_voltage_mv <= pack;
      req_discharge_current_ma <= cur;
      do @(posedge clock); while (req_stall);
      offered++;
      @(negedge clock);
   endtask

   // Most samples are aimed at the curve for the present cell count and resistance.
   task automatic offer_random_sample();
      int unsigned n_cells;
      int unsigned sag;
      int unsigned cell_mv;
      int unsigned pack_mv;
      logic [bsoc_pkg::I_W-1:0] cur;
      n_cells = (cells_now == 0) ? 1 : int'(cells_now);
      case ($urandom_range(0, 7))
         0, 1:    cur = bsoc_pkg::I_W'($urandom_range(0, 100));
         2, 3:    cur = bsoc_pkg::I_W'($urandom_range(101, 1200));
         4, 5:    cur = bsoc_pkg::I_W'($urandom_range(1201, 3000));
         6:       cur = bsoc_pkg::I_W'($urandom_range(0, 1) ? $urandom_range(97, 104) :
                                                           $urandom_range(1197, 1204));
         default: cur = bsoc_pkg::I_W'($urandom_range(0, 65535));
      endcase
      sag = (cur > 100) ? (int'(cur) * int'(ir_now)) / 1000 : 0;
      if ($urandom_range(0, 9) == 0) begin
         pack_mv = $urandom_range(0, 65535);
      end else begin
         cell_mv = $urandom_range(2450, 4300);
         cell_mv = (cell_mv > sag) ? cell_mv - sag : 0;
         pack_mv = cell_mv * n_cells + $urandom_range(0, n_cells - 1);
         if (pack_mv > 65535) pack_mv = 65535;
      end
      offer_sample(pack_mv[bsoc_pkg::V_W-1:0], cur);
   endtask

   task automatic wait_drained();
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Upper data bits of the cell count write are junk; only the low five bits count.
   task automatic apply_setting(input logic [bsoc_pkg::CELLS_W-1:0] cells,
                                input logic [bsoc_pkg::IR_W-1:0] ir);
      req_valid <= 1'b0;
      wait_drained();
      csr_write_en <= 1'b1;
      csr_index <= bsoc_pkg::CSR_CELLS_IN_PACK;
      csr_wdata <= {(bsoc_pkg::CSR_W-bsoc_pkg::CELLS_W)'($urandom), cells};
      @(negedge clock);
      csr_index <= bsoc_pkg::CSR_INTERNAL_RES;
      csr_wdata <= ir;
      @(negedge clock);
      csr_write_en <= 1'b0;
      cells_now = cells;
      ir_now = ir;
      @(negedge clock);
   endtask

   initial begin : result_sink
      int unsigned hold;
      int unsigned taken;
      taken = 0;
      rsp_stall = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         // One long hold lets the pipeline fill and push back on the sender.
         if (taken == LONG_HOLD_AT) hold = LONG_HOLD_CYCLES;
         else if (taken % 64 < 16) hold = 0;
         else hold = $urandom_range(0, 13);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_pack_voltage_mv = '0;
      req_discharge_current_ma = '0;
      csr_write_en = 1'b0;
      csr_index = bsoc_pkg::CSR_CELLS_IN_PACK;
      csr_wdata = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < EDGE_ITEMS; i++) offer_sample(EDGE_PACK[i], EDGE_CUR[i]);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       ;
            1:       apply_setting(5'd1, 10'd0);
            2:       apply_setting(5'd16, 10'd1000);
            3:       apply_setting(5'd0, 10'd1023);
            4:       apply_setting(5'd31, 10'd1001);
            5:       apply_setting(5'd4, 10'd250);
            default: apply_setting(bsoc_pkg::CELLS_W'($urandom_range(1, 16)),
                                   bsoc_pkg::IR_W'($urandom_range(0, 1000)));
         endcase
         for (int k = 0; k < ITEMS_PER_PHASE; k++) offer_random_sample();
      end

      req_valid <= 1'b0;
      wait_drained();
      $display("Covered %0d samples, %0d results checked, over %0d register settings.",
               offered, checked, PHASES);
      $display("Settings ran from reset values to zero and out-of-range counts and resistances.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS battery_soc_from_voltage");
      end else begin
         $display("FAIL battery_soc_from_voltage");
      end
      $finish;
   end

endmodule
